@@ rtl/local_alignment_score_fill_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the local alignment score fill
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LOCAL_ALIGNMENT_SCORE_FILL_ASSERT_SVH
`define LOCAL_ALIGNMENT_SCORE_FILL_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LASF_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("local_alignment_score_fill: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LASF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("local_alignment_score_fill: next-cycle check failed");

`endif

@@ rtl/lasf_pkg.sv @@
// ----------------------------------------------------------------------------
// lasf_pkg
// Widths, codes and the token type shared by the alignment cell chain.
// ----------------------------------------------------------------------------
package lasf_pkg;

  localparam int REF_MAX_DEF = 256;
  localparam int SEQ_MAX_DEF = 1024;

  localparam int BASE_W     = 8;
  localparam int POS_W      = 8;
  localparam int MATCH_W    = 7;
  localparam int GAP_W      = 7;
  localparam int LEN_W      = 9;
  localparam int SCORE_W    = 15;
  localparam int EXT_W      = SCORE_W + 2;
  localparam int ROW_OUT_W  = 11;
  localparam int COL_OUT_W  = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam int SCORE_LIMIT = 32767;

  localparam logic [MATCH_W-1:0] MATCH_RST = 7'd2;
  localparam logic [GAP_W-1:0]   GAP_RST   = 7'd1;
  localparam logic [LEN_W-1:0]   LEN_RST   = 9'd256;

  typedef enum logic {
    CMD_REF = 1'b0,
    CMD_SEQ = 1'b1
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MATCH = 2'd0,
    CFG_GAP   = 2'd1,
    CFG_LEN   = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [MATCH_W-1:0] match_score;
    logic [GAP_W-1:0]   gap_penalty;
  } cfg_t;

  // One item travelling down the chain, plus the running row values.
  typedef struct packed {
    logic               valid;
    cmd_t               cmd;
    logic               last;
    logic [BASE_W-1:0]  base;
    logic [POS_W-1:0]   pos;
    logic [SCORE_W-1:0] left;
    logic [SCORE_W-1:0] diag;
    logic [SCORE_W-1:0] best_score;
  } tok_t;

endpackage

@@ rtl/lasf_cell.sv @@
// ----------------------------------------------------------------------------
// lasf_cell
// One reference column: holds its reference base and the score of the
// previous row, computes one matrix cell per passing sequence item in the active length.
// ----------------------------------------------------------------------------
module lasf_cell #(
  parameter int IDX = 0,
  parameter int CW  = 9,
  parameter int RW  = 11
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  lasf_pkg::cfg_t  cfg,
  input  logic [CW-1:0]   cols,
  input  lasf_pkg::tok_t  in_tok,
  input  logic [RW-1:0]   in_row,
  input  logic [CW-1:0]   in_col,
  output lasf_pkg::tok_t  out_tok,
  output logic [RW-1:0]   out_row,
  output logic [CW-1:0]   out_col
);
  import lasf_pkg::*;

  localparam logic [CW-1:0] COL_NUM = CW'(IDX + 1);

  logic [BASE_W-1:0]  ref_r;
  logic [SCORE_W-1:0] up_r, up_nxt;
  logic               valid_r;
  tok_t               tok_r, tok_nxt;
  logic [RW-1:0]      row_r;
  logic [CW-1:0]      col_r, col_nxt;

  logic is_seq, active, hit;
  logic signed [EXT_W-1:0] diag_s, left_s, up_s, best_s;
  logic [SCORE_W-1:0] v;

  always_comb begin
    is_seq = in_tok.valid && (in_tok.cmd == CMD_SEQ);
    active = is_seq && (32'(cols) > 32'(IDX));
    hit    = in_tok.valid && (in_tok.cmd == CMD_REF) && (32'(in_tok.pos) == 32'(IDX));

    if (ref_r == in_tok.base) begin
      diag_s = $signed(EXT_W'(in_tok.diag) + EXT_W'(cfg.match_score));
    end else begin
      diag_s = $signed(EXT_W'(in_tok.diag) - EXT_W'(cfg.match_score));
    end
    left_s = $signed(EXT_W'(in_tok.left) - EXT_W'(cfg.gap_penalty));
    up_s   = $signed(EXT_W'(up_r) - EXT_W'(cfg.gap_penalty));

    best_s = '0;
    if (diag_s > best_s) best_s = diag_s;
    if (left_s > best_s) best_s = left_s;
    if (up_s > best_s) best_s = up_s;
    if (best_s > $signed(EXT_W'(SCORE_LIMIT))) best_s = $signed(EXT_W'(SCORE_LIMIT));
    v = best_s[SCORE_W-1:0];

    tok_nxt = in_tok;
    col_nxt = in_col;
    up_nxt  = up_r;
    // Columns beyond the active length pass the item on untouched.
    if (active) begin
      tok_nxt.left = v;
      tok_nxt.diag = up_r;
      up_nxt       = v;
      if (v > in_tok.best_score) begin
        tok_nxt.best_score = v;
        col_nxt            = COL_NUM;
      end
    end
    // The final row of a sequence leaves a zero row behind for the next one.
    if (is_seq && in_tok.last) up_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (adv && hit) ref_r <= in_tok.base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      up_r    <= '0;
    end else if (adv) begin
      valid_r <= tok_nxt.valid;
      up_r    <= up_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
      row_r <= in_row;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    out_tok       = tok_r;
    out_tok.valid = valid_r;
  end

  assign out_row = row_r;
  assign out_col = col_r;

endmodule

@@ rtl/lasf_best.sv @@
// ----------------------------------------------------------------------------
// lasf_best
// Merges each finished row's best cell into the sequence best and holds
// the result item until it is taken.
// ----------------------------------------------------------------------------
module lasf_best #(
  parameter int CW = 9,
  parameter int RW = 11
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  lasf_pkg::tok_t                     exit_tok,
  input  logic [RW-1:0]                      exit_row,
  input  logic [CW-1:0]                      exit_col,
  input  logic                               out_stall,
  output logic                               adv,
  output logic                               out_valid,
  output logic [lasf_pkg::ROW_OUT_W-1:0]     out_best_row,
  output logic [lasf_pkg::COL_OUT_W-1:0]     out_best_col,
  output logic [lasf_pkg::SCORE_W-1:0]       out_best_score
);
  import lasf_pkg::*;

  logic [SCORE_W-1:0] top_score_r;
  logic [RW-1:0]      top_row_r;
  logic [CW-1:0]      top_col_r;
  logic               out_valid_r;
  logic [ROW_OUT_W-1:0] res_row_r;
  logic [COL_OUT_W-1:0] res_col_r;
  logic [SCORE_W-1:0]   res_score_r;

  logic               row_done, take;
  logic [SCORE_W-1:0] m_score;
  logic [RW-1:0]      m_row;
  logic [CW-1:0]      m_col;

  assign adv = !out_valid_r || !out_stall;

  always_comb begin
    row_done = exit_tok.valid && (exit_tok.cmd == CMD_SEQ);
    // The row best is the earliest maximum of its row, so a strict compare
    // keeps the first best cell in row-major order.
    take     = row_done && (exit_tok.best_score > top_score_r);
    m_score  = take ? exit_tok.best_score : top_score_r;
    m_row    = take ? exit_row : top_row_r;
    m_col    = take ? exit_col : top_col_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_score_r <= '0;
      top_row_r   <= '0;
      top_col_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= row_done && exit_tok.last;
      if (row_done) begin
        if (exit_tok.last) begin
          top_score_r <= '0;
          top_row_r   <= '0;
          top_col_r   <= '0;
        end else begin
          top_score_r <= m_score;
          top_row_r   <= m_row;
          top_col_r   <= m_col;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && row_done && exit_tok.last) begin
      res_row_r   <= ROW_OUT_W'(m_row);
      res_col_r   <= COL_OUT_W'(m_col);
      res_score_r <= m_score;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_best_row   = res_row_r;
  assign out_best_col   = res_col_r;
  assign out_best_score = res_score_r;

endmodule

@@ rtl/local_alignment_score_fill.sv @@
// ----------------------------------------------------------------------------
// local_alignment_score_fill
// Smith-Waterman score fill with linear gap penalty on a chain of
// REF_MAX column cells; reports the best cell at the end of each sequence.
// ----------------------------------------------------------------------------
//  channel | ports                                         | direction
//  input   | in_valid in_stall in_cmd in_base in_ref_pos in_last | in
//  result  | out_valid out_stall out_best_row/col/score    | out
//  config  | cfg_we cfg_index cfg_data                     | in
//
//  One item is accepted per cycle unless in_stall is high; items move
//  one cell per cycle when not stalled, then the result is registered.
//  Reference writes travel the chain too and stay in order with rows.
//  Reset clears the chain, the kept row and the best cell; the reference
//  bases are undefined until written.
//  A waiting result that is stalled freezes the whole chain and raises
//  in_stall until it is taken.
// ----------------------------------------------------------------------------
module local_alignment_score_fill #(
  parameter int REF_MAX = lasf_pkg::REF_MAX_DEF,
  parameter int SEQ_MAX = lasf_pkg::SEQ_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [lasf_pkg::BASE_W-1:0]       in_base,
  input  logic [lasf_pkg::POS_W-1:0]        in_ref_pos,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lasf_pkg::ROW_OUT_W-1:0]    out_best_row,
  output logic [lasf_pkg::COL_OUT_W-1:0]    out_best_col,
  output logic [lasf_pkg::SCORE_W-1:0]      out_best_score,
  input  logic                              cfg_we,
  input  logic [lasf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [lasf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import lasf_pkg::*;

  `include "local_alignment_score_fill_assert.svh"

  localparam int CW = $clog2(REF_MAX + 1);
  localparam int RW = $clog2(SEQ_MAX + 1);

  logic [MATCH_W-1:0] match_r;
  logic [GAP_W-1:0]   gap_r;
  logic [LEN_W-1:0]   len_r;
  logic [RW-1:0]      row_cnt_r, row_nxt;

  cfg_t          cfg;
  logic [CW-1:0] cols;
  logic          adv, accept, acc_seq;

  tok_t          chain_tok [REF_MAX+1];
  logic [RW-1:0] chain_row [REF_MAX+1];
  logic [CW-1:0] chain_col [REF_MAX+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= MATCH_RST;
      gap_r   <= GAP_RST;
      len_r   <= LEN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH: match_r <= cfg_data[MATCH_W-1:0];
        CFG_GAP:   gap_r   <= cfg_data[GAP_W-1:0];
        CFG_LEN:   len_r   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.match_score = match_r;
    cfg.gap_penalty = gap_r;
    cols = (32'(len_r) > 32'(REF_MAX)) ? CW'(REF_MAX) : CW'(len_r);
  end

  assign in_stall = !adv;
  assign accept   = in_valid && adv;
  assign acc_seq  = accept && (in_cmd == CMD_SEQ);

  // The row number saturates at SEQ_MAX.
  assign row_nxt = (row_cnt_r == RW'(SEQ_MAX)) ? row_cnt_r : row_cnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
    end else if (acc_seq) begin
      row_cnt_r <= in_last ? '0 : row_nxt;
    end
  end

  always_comb begin
    chain_tok[0].valid      = in_valid;
    chain_tok[0].cmd        = cmd_t'(in_cmd);
    chain_tok[0].last       = in_last;
    chain_tok[0].base       = in_base;
    chain_tok[0].pos        = in_ref_pos;
    chain_tok[0].left       = '0;
    chain_tok[0].diag       = '0;
    chain_tok[0].best_score = '0;
    chain_row[0]            = row_nxt;
    chain_col[0]            = '0;
  end

  for (genvar i = 0; i < REF_MAX; i++) begin : g_cell
    lasf_cell #(
      .IDX (i),
      .CW  (CW),
      .RW  (RW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .cfg     (cfg),
      .cols    (cols),
      .in_tok  (chain_tok[i]),
      .in_row  (chain_row[i]),
      .in_col  (chain_col[i]),
      .out_tok (chain_tok[i+1]),
      .out_row (chain_row[i+1]),
      .out_col (chain_col[i+1])
    );
  end

  lasf_best #(
    .CW (CW),
    .RW (RW)
  ) u_best (
    .clk            (clk),
    .rst_n          (rst_n),
    .exit_tok       (chain_tok[REF_MAX]),
    .exit_row       (chain_row[REF_MAX]),
    .exit_col       (chain_col[REF_MAX]),
    .out_stall      (out_stall),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_best_row   (out_best_row),
    .out_best_col   (out_best_col),
    .out_best_score (out_best_score)
  );

  `LASF_ASSERT_NEXT(a_row_restart, acc_seq && in_last, row_cnt_r == '0)
  `LASF_ASSERT_NEXT(a_row_step, acc_seq && !in_last && (row_cnt_r != RW'(SEQ_MAX)), row_cnt_r == $past(row_cnt_r) + 1'b1)
  `LASF_ASSERT_SAME(a_zero_score_no_cell, out_valid && (out_best_score == '0), (out_best_row == '0) && (out_best_col == '0))
  `LASF_ASSERT_SAME(a_pos_score_has_cell, out_valid && (out_best_score != '0), (out_best_row != '0) && (out_best_col != '0))

endmodule
